// ----- rtl/core/hrhp_pkg.sv -----
// Shared types, codes and character classes of the HTTP request header parser.
package hrhp_pkg;

  // Width of the version accumulators
  localparam int unsigned VersionBits = 8;

  // Characters that the grammar checks against
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChDel   = 8'd127;
  localparam logic [7:0] ChCtlHi = 8'd31;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [3:0] DecBase = 4'd10;

  typedef enum logic [4:0] {
    PH_METHOD_START, PH_METHOD, PH_URI, PH_H, PH_T1, PH_T2, PH_P, PH_SLASH,
    PH_MAJOR_START, PH_MAJOR, PH_MINOR_START, PH_MINOR, PH_LF1,
    PH_LINE_START, PH_LWS, PH_NAME, PH_SPACE_VALUE, PH_VALUE, PH_LF2, PH_LF3
  } phase_e;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RL_NONE   = 3'd0,
    RL_METHOD = 3'd1,
    RL_URI    = 3'd2,
    RL_NAME   = 3'd3,
    RL_VALUE  = 3'd4
  } role_e;

  // Parser state carried from one byte to the next
  typedef struct packed {
    phase_e                 phase;
    logic                   seen_header;
    logic [VersionBits-1:0] major_acc;
    logic [VersionBits-1:0] minor_acc;
  } hrhp_state_t;

  // Result of one byte
  typedef struct packed {
    status_e    status;
    logic [7:0] byte_out;
    role_e      byte_role;
    logic       header_begin;
    logic [7:0] version_major;
    logic [7:0] version_minor;
  } hrhp_result_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= ChCtlHi) || (b == ChDel);
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    logic sep;
    case (b)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_separator(b);
  endfunction

  function automatic logic is_dec(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

// ----- rtl/core/hrhp_if.sv -----
// Request and result channel interfaces of the HTTP request header parser.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrhp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] byte_out;
  logic [2:0] byte_role;
  logic       header_begin;
  logic [7:0] version_major;
  logic [7:0] version_minor;

  modport source (output valid, output status, output byte_out, output byte_role,
                  output header_begin, output version_major, output version_minor,
                  input ready);
  modport sink   (input valid, input status, input byte_out, input byte_role,
                  input header_begin, input version_major, input version_minor,
                  output ready);
endinterface

// ----- rtl/core/hrhp_step.sv -----
// Grammar step of the parser: next state and result for one byte.
module hrhp_step (
  input  hrhp_pkg::hrhp_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   restart_i,
  output hrhp_pkg::hrhp_state_t  state_o,
  output hrhp_pkg::hrhp_result_t result_o
);
  import hrhp_pkg::*;

  localparam logic [VersionBits-1:0] VersionMax = '1;
  localparam logic [VersionBits-1:0] Clip8      = VersionBits'(8'hFF);

  // acc * 10 + digit, saturating at the accumulator's maximum
  function automatic logic [VersionBits-1:0] acc_digit(
    input logic [VersionBits-1:0] acc,
    input logic [7:0]             b
  );
    logic [VersionBits+3:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (VersionBits+4)'(b - ChZero);
    return (v > {4'd0, VersionMax}) ? VersionMax : v[VersionBits-1:0];
  endfunction

  function automatic logic [7:0] clip_out(input logic [VersionBits-1:0] acc);
    return (acc > Clip8) ? 8'hFF : 8'(acc);
  endfunction

  hrhp_state_t cur;
  hrhp_state_t nxt;
  logic        bad;
  status_e     status;
  role_e       role;
  logic        hbegin;
  logic        is_ws;

  assign is_ws = (data_byte_i == ChSpace) || (data_byte_i == ChTab);

  // Restart first, then walk one grammar step
  always_comb begin
    cur = state_i;
    if (restart_i) begin
      cur = '0;
      cur.phase = PH_METHOD_START;
    end
    nxt    = cur;
    bad    = 1'b0;
    status = ST_PENDING;
    role   = RL_NONE;
    hbegin = 1'b0;
    case (cur.phase)
      PH_METHOD_START: begin
        if (is_token(data_byte_i)) begin
          nxt.phase = PH_METHOD;
          role = RL_METHOD;
        end else bad = 1'b1;
      end
      PH_METHOD: begin
        if (data_byte_i == ChSpace) nxt.phase = PH_URI;
        else if (is_token(data_byte_i)) role = RL_METHOD;
        else bad = 1'b1;
      end
      PH_URI: begin
        if (data_byte_i == ChSpace) nxt.phase = PH_H;
        else if (is_ctl(data_byte_i)) bad = 1'b1;
        else role = RL_URI;
      end
      PH_H: begin
        if (data_byte_i == ChH) nxt.phase = PH_T1; else bad = 1'b1;
      end
      PH_T1: begin
        if (data_byte_i == ChT) nxt.phase = PH_T2; else bad = 1'b1;
      end
      PH_T2: begin
        if (data_byte_i == ChT) nxt.phase = PH_P; else bad = 1'b1;
      end
      PH_P: begin
        if (data_byte_i == ChP) nxt.phase = PH_SLASH; else bad = 1'b1;
      end
      PH_SLASH: begin
        if (data_byte_i == ChSlash) begin
          nxt.major_acc = '0;
          nxt.minor_acc = '0;
          nxt.phase = PH_MAJOR_START;
        end else bad = 1'b1;
      end
      PH_MAJOR_START: begin
        if (is_dec(data_byte_i)) begin
          nxt.major_acc = acc_digit(cur.major_acc, data_byte_i);
          nxt.phase = PH_MAJOR;
        end else bad = 1'b1;
      end
      PH_MAJOR: begin
        if (data_byte_i == ChDot) nxt.phase = PH_MINOR_START;
        else if (is_dec(data_byte_i)) nxt.major_acc = acc_digit(cur.major_acc, data_byte_i);
        else bad = 1'b1;
      end
      PH_MINOR_START: begin
        if (is_dec(data_byte_i)) begin
          nxt.minor_acc = acc_digit(cur.minor_acc, data_byte_i);
          nxt.phase = PH_MINOR;
        end else bad = 1'b1;
      end
      PH_MINOR: begin
        if (data_byte_i == ChCr) nxt.phase = PH_LF1;
        else if (is_dec(data_byte_i)) nxt.minor_acc = acc_digit(cur.minor_acc, data_byte_i);
        else bad = 1'b1;
      end
      PH_LF1: begin
        if (data_byte_i == ChLf) nxt.phase = PH_LINE_START; else bad = 1'b1;
      end
      PH_LINE_START: begin
        if (data_byte_i == ChCr) nxt.phase = PH_LF3;
        else if (cur.seen_header && is_ws) nxt.phase = PH_LWS;
        else if (is_token(data_byte_i)) begin
          nxt.seen_header = 1'b1;
          nxt.phase = PH_NAME;
          role = RL_NAME;
          hbegin = 1'b1;
        end else bad = 1'b1;
      end
      PH_LWS: begin
        // folded continuation: skip leading whitespace, then value bytes
        if (data_byte_i == ChCr) nxt.phase = PH_LF2;
        else if (is_ws) nxt.phase = PH_LWS;
        else if (is_ctl(data_byte_i)) bad = 1'b1;
        else begin
          nxt.phase = PH_VALUE;
          role = RL_VALUE;
        end
      end
      PH_NAME: begin
        if (data_byte_i == ChColon) nxt.phase = PH_SPACE_VALUE;
        else if (is_token(data_byte_i)) role = RL_NAME;
        else bad = 1'b1;
      end
      PH_SPACE_VALUE: begin
        if (data_byte_i == ChSpace) nxt.phase = PH_VALUE; else bad = 1'b1;
      end
      PH_VALUE: begin
        if (data_byte_i == ChCr) nxt.phase = PH_LF2;
        else if (is_ctl(data_byte_i)) bad = 1'b1;
        else role = RL_VALUE;
      end
      PH_LF2: begin
        if (data_byte_i == ChLf) nxt.phase = PH_LINE_START; else bad = 1'b1;
      end
      PH_LF3: begin
        // stays here after completion; only LF keeps reporting done
        if (data_byte_i == ChLf) status = ST_DONE; else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nxt    = cur;
      status = ST_BAD;
      role   = RL_NONE;
      hbegin = 1'b0;
    end
  end

  assign state_o = nxt;

  // Result fields
  always_comb begin
    result_o.status        = status;
    result_o.byte_out      = data_byte_i;
    result_o.byte_role     = role;
    result_o.header_begin  = hbegin;
    result_o.version_major = clip_out(nxt.major_acc);
    result_o.version_minor = clip_out(nxt.minor_acc);
  end

endmodule

// ----- rtl/core/http_request_header_parser_core.sv -----
// HTTP/1.x request-line and header parser: one byte per cycle when rsp_o is not stalled, tagged output.
//
// Usage:
//   req_i carries one request byte (data_byte) and a restart flag per request.
//   A request is taken when valid and ready are both high at a rising clk_i.
//   restart returns the grammar to the method start before that byte is parsed.
//   rsp_o returns one result per request, in order: status (pending, complete,
//   malformed), the byte itself, its role, a header start flag and the major
//   and minor version numbers accumulated so far.
// Timing:
//   The result is registered: the request sits in the input register, then
//   the grammar step loads the result register. Throughput is one byte per
//   cycle while rsp_o is not stalled; the grammar step reads the state
//   written by the previous byte.
// Reset:
//   rst_ni (asynchronous, active low) empties both registers and puts the
//   parser at the method start with cleared version counters.
// Stalls:
//   When rsp_o.ready is low the result is held; one more request may sit in
//   the input register, after which req_i.ready drops. Nothing is dropped.
module http_request_header_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  hrhp_in_if.sink           req_i,
  hrhp_out_if.source        rsp_o
);
  import hrhp_pkg::*;

  // Input register
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_restart_q;

  // Parser state and result register
  hrhp_state_t  state_q, state_d;
  hrhp_result_t res_q, res_d;
  logic         out_valid_q;

  logic         out_adv;
  logic         step_fire;

  // Result register can load when empty or being drained
  assign out_adv   = !out_valid_q || rsp_o.ready;
  assign step_fire = in_valid_q && out_adv;
  assign req_i.ready = !in_valid_q || out_adv;

  hrhp_step u_step (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .restart_i   (in_restart_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_byte_q    <= req_i.data_byte;
      in_restart_q <= req_i.restart;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_METHOD_START, seen_header: 1'b0,
                   major_acc: '0, minor_acc: '0};
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = res_q.status;
  assign rsp_o.byte_out      = res_q.byte_out;
  assign rsp_o.byte_role     = res_q.byte_role;
  assign rsp_o.header_begin  = res_q.header_begin;
  assign rsp_o.version_major = res_q.version_major;
  assign rsp_o.version_minor = res_q.version_minor;

endmodule

// ----- rtl/core/hrhp_checker.sv -----
// Port-level checks of the HTTP request header parser, bound to the top level.
module hrhp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] status_i,
  input logic [7:0] byte_out_i,
  input logic [2:0] byte_role_i,
  input logic       header_begin_i
);
  import hrhp_pkg::*;

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // Malformed bytes carry no role and no header start
  a_bad_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_BAD) |-> (byte_role_i == RL_NONE) && !header_begin_i)
    else $error("malformed byte tagged");

  // A header start is the first byte of a name and is never a completion
  a_begin_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && header_begin_i |-> (byte_role_i == RL_NAME) && (status_i == ST_PENDING))
    else $error("header start outside a header name");

  // Completion is reported only on the final LF, as a delimiter
  a_done_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_DONE) |-> (byte_out_i == ChLf) && (byte_role_i == RL_NONE))
    else $error("completion on a byte other than LF");

endmodule

bind http_request_header_parser_core hrhp_checker u_hrhp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .byte_out_i     (rsp_o.byte_out),
  .byte_role_i    (rsp_o.byte_role),
  .header_begin_i (rsp_o.header_begin)
);
